[rtl/cosim_pkg.sv]
// ----------------------------------------------------------------------------
// cosim_pkg
// Shared widths, types and state codes for the cosine similarity block.
// ----------------------------------------------------------------------------
package cosim_pkg;

  localparam int ElemW  = 16;
  localparam int AbW    = 42;
  localparam int SqW    = 41;
  localparam int RootW  = 35;
  localparam int RadW   = 2 * RootW;
  localparam int RemW   = RootW + 2;
  localparam int ProdW  = 2 * RootW;
  localparam int NumW   = AbW + 43;
  localparam int QW     = 16;
  localparam int MulLoW = 18;

  typedef struct packed {
    logic signed [AbW-1:0] ab;
    logic [SqW-1:0]        aa;
    logic [SqW-1:0]        bb;
  } sums_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } back_state_e;

endpackage

[rtl/cosine_similarity.sv]
// ----------------------------------------------------------------------------
// cosine_similarity
// Streaming cosine similarity of two Q2.14 vectors, result in Q1.15.
// ----------------------------------------------------------------------------
// Input channel: one element pair per item (a_elem_i, b_elem_i), last_i set
// on the final pair. Items are taken one per cycle; in_stall_o rises only
// when the final pair of a vector finds the two-entry sum queue full.
// Output channel: one item (cosine_o, zero_norm_o) per vector pair.
// From final pair to result: product and sum stages, queue, 35 root steps
// run in parallel for both norms, 2 multiply passes, up to 16 divide steps,
// output register. The back end handles one vector pair at a time, so it
// takes no new sums before the last result has left; short vectors stall
// the input once the queue fills.
// Zero norms skip the roots and divide and give cosine 0, zero_norm 1.
// Reset clears the sums, the queue and the back-end state. While out_stall_i
// is high the result holds; the front keeps accumulating the next vector.
// ----------------------------------------------------------------------------
module cosine_similarity (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cosim_pkg::ElemW-1:0]  a_elem_i,
  input  logic signed [cosim_pkg::ElemW-1:0]  b_elem_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cosim_pkg::QW-1:0]     cosine_o,
  output logic                                zero_norm_o
);
  import cosim_pkg::*;

  sums_t     wsums, rsums;
  fifo_ctl_t ctl;
  logic      full, empty;
  logic [1:0] count;

  cosim_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .a_elem_i, .b_elem_i, .last_i,
    .full_i(full), .push_o(ctl.push), .sums_o(wsums)
  );

  cosim_fifo u_fifo (
    .clk_i, .rst_ni, .ctl_i(ctl), .wdata_i(wsums), .rdata_o(rsums),
    .full_o(full), .empty_o(empty), .count_o(count)
  );

  cosim_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .sums_i(rsums), .pop_o(ctl.pop),
    .out_valid_o, .out_stall_i, .cosine_o, .zero_norm_o
  );

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) count != 2'd3)
    else $error("queue count overflow");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> cosine_o == '0)
    else $error("zero norm with nonzero cosine");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop |-> !empty)
    else $error("pop from empty queue");

endmodule

[rtl/cosim_front.sv]
// ----------------------------------------------------------------------------
// cosim_front
// Takes element pairs, forms products, keeps saturating running sums and
// hands the sums of a finished vector pair to the queue.
// ----------------------------------------------------------------------------
module cosim_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cosim_pkg::ElemW-1:0]  a_elem_i,
  input  logic signed [cosim_pkg::ElemW-1:0]  b_elem_i,
  input  logic                                last_i,
  input  logic                                full_i,
  output logic                                push_o,
  output cosim_pkg::sums_t                    sums_o
);
  import cosim_pkg::*;

  logic                           s1_valid_q, s1_last_q;
  logic signed [2*ElemW-1:0]      pab_q, paa_q, pbb_q;
  logic signed [AbW-1:0]          ab_q, ab_d;
  logic [SqW-1:0]                 aa_q, aa_d, bb_q, bb_d;
  logic signed [AbW:0]            ab_sum;
  logic [SqW:0]                   aa_sum, bb_sum;
  logic                           blocked;

  assign blocked    = s1_valid_q & s1_last_q & full_i;
  assign in_stall_o = blocked;
  assign push_o     = s1_valid_q & s1_last_q & ~full_i;

  always_comb begin
    ab_sum = {ab_q[AbW-1], ab_q} + {{(AbW+1-2*ElemW){pab_q[2*ElemW-1]}}, pab_q};
    aa_sum = {1'b0, aa_q} + {{(SqW+1-2*ElemW+1){1'b0}}, paa_q[2*ElemW-2:0]};
    bb_sum = {1'b0, bb_q} + {{(SqW+1-2*ElemW+1){1'b0}}, pbb_q[2*ElemW-2:0]};
    if (ab_sum[AbW] != ab_sum[AbW-1]) begin
      ab_d = ab_sum[AbW] ? {1'b1, {(AbW-1){1'b0}}} : {1'b0, {(AbW-1){1'b1}}};
    end else begin
      ab_d = ab_sum[AbW-1:0];
    end
    aa_d = aa_sum[SqW] ? {SqW{1'b1}} : aa_sum[SqW-1:0];
    bb_d = bb_sum[SqW] ? {SqW{1'b1}} : bb_sum[SqW-1:0];
  end

  assign sums_o = '{ab: ab_d, aa: aa_d, bb: bb_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      ab_q       <= '0;
      aa_q       <= '0;
      bb_q       <= '0;
    end else if (!blocked) begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= last_i;
      if (s1_valid_q) begin
        if (s1_last_q) begin
          ab_q <= '0;
          aa_q <= '0;
          bb_q <= '0;
        end else begin
          ab_q <= ab_d;
          aa_q <= aa_d;
          bb_q <= bb_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!blocked) begin
      pab_q <= a_elem_i * b_elem_i;
      paa_q <= a_elem_i * a_elem_i;
      pbb_q <= b_elem_i * b_elem_i;
    end
  end

endmodule

[rtl/cosim_fifo.sv]
// ----------------------------------------------------------------------------
// cosim_fifo
// Two-entry queue of finished sums between front and back.
// ----------------------------------------------------------------------------
module cosim_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cosim_pkg::fifo_ctl_t   ctl_i,
  input  cosim_pkg::sums_t       wdata_i,
  output cosim_pkg::sums_t       rdata_o,
  output logic                   full_o,
  output logic                   empty_o,
  output logic [1:0]             count_o
);
  import cosim_pkg::*;

  sums_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (ctl_i.push) wr_q <= ~wr_q;
      if (ctl_i.pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, ctl_i.push} - {1'b0, ctl_i.pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[wr_q] <= wdata_i;
  end

endmodule

[rtl/cosim_back.sv]
// ----------------------------------------------------------------------------
// cosim_back
// Per vector pair: two digit-serial roots, a two-pass norm product and a
// restoring divide, then a held output register.
// ----------------------------------------------------------------------------
module cosim_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  cosim_pkg::sums_t                    sums_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cosim_pkg::QW-1:0]     cosine_o,
  output logic                                zero_norm_o
);
  import cosim_pkg::*;

  back_state_e           st_q, st_d;
  logic [5:0]            cnt_q, cnt_d;
  logic                  neg_q;
  logic [RadW-1:0]       rada_q, radb_q;
  logic [RemW-1:0]       rema_q, remb_q;
  logic [RootW-1:0]      roota_q, rootb_q;
  logic [ProdW-1:0]      prod_q;
  logic [NumW-1:0]       num_q, dsh_q;
  logic [QW-1:0]         q_q;
  logic signed [QW-1:0]  cos_q;
  logic                  zero_q;
  logic                  load, root_step, mul_step, div_step, fin;
  logic [RemW+1:0]       ta, tb, tra, trb;
  logic                  gea, geb, gediv;
  logic [RootW+MulLoW-1:0] pp;
  logic [QW-1:0]         res;

  always_comb begin
    ta  = {rema_q, rada_q[RadW-1 -: 2]};
    tb  = {remb_q, radb_q[RadW-1 -: 2]};
    tra = {1'b0, roota_q, 2'b01};
    trb = {1'b0, rootb_q, 2'b01};
    gea = ta >= tra;
    geb = tb >= trb;
    pp  = roota_q * (cnt_q[0] ? {1'b0, rootb_q[RootW-1:MulLoW]}
                              : rootb_q[MulLoW-1:0]);
    gediv = num_q >= dsh_q;
    if (neg_q) res = QW'(0) - q_q;
    else       res = q_q[QW-1] ? {1'b0, {(QW-1){1'b1}}} : q_q;
  end

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    load = 1'b0;
    root_step = 1'b0;
    mul_step = 1'b0;
    div_step = 1'b0;
    fin = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          load = 1'b1;
          cnt_d = 6'(RootW - 1);
          st_d = (sums_i.aa == '0 || sums_i.bb == '0) ? ST_OUT : ST_ROOT;
        end
      end
      ST_ROOT: begin
        root_step = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          st_d = ST_MUL;
          cnt_d = '0;
        end
      end
      ST_MUL: begin
        mul_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[0]) begin
          st_d = ST_DIV;
          cnt_d = 6'(QW - 1);
        end
      end
      ST_DIV: begin
        div_step = 1'b1;
        cnt_d = cnt_q - 6'd1;
        if ((cnt_q == 6'(QW - 1) && gediv) || cnt_q == '0) begin
          st_d = ST_OUT;
          fin = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign pop_o       = load;
  assign out_valid_o = st_q == ST_OUT;
  assign cosine_o    = cos_q;
  assign zero_norm_o = zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q   <= sums_i.ab[AbW-1];
      num_q   <= {(sums_i.ab[AbW-1] ? -sums_i.ab : sums_i.ab), 43'd0};
      rada_q  <= {1'b0, sums_i.aa, 28'd0};
      radb_q  <= {1'b0, sums_i.bb, 28'd0};
      rema_q  <= '0;
      remb_q  <= '0;
      roota_q <= '0;
      rootb_q <= '0;
      prod_q  <= '0;
      q_q     <= '0;
      zero_q  <= (sums_i.aa == '0 || sums_i.bb == '0);
      cos_q   <= '0;
    end
    if (root_step) begin
      rada_q  <= {rada_q[RadW-3:0], 2'b00};
      radb_q  <= {radb_q[RadW-3:0], 2'b00};
      rema_q  <= gea ? RemW'(ta - tra) : ta[RemW-1:0];
      remb_q  <= geb ? RemW'(tb - trb) : tb[RemW-1:0];
      roota_q <= {roota_q[RootW-2:0], gea};
      rootb_q <= {rootb_q[RootW-2:0], geb};
    end
    if (mul_step) begin
      if (cnt_q[0]) begin
        prod_q <= prod_q + {pp[ProdW-MulLoW-1:0], {MulLoW{1'b0}}};
        dsh_q  <= {prod_q + {pp[ProdW-MulLoW-1:0], {MulLoW{1'b0}}}, 15'd0};
      end else begin
        prod_q <= ProdW'(pp);
      end
    end
    if (div_step) begin
      dsh_q <= {1'b0, dsh_q[NumW-1:1]};
      if (gediv) begin
        if (cnt_q == 6'(QW - 1)) q_q <= {1'b1, {(QW-1){1'b0}}};
        else begin
          num_q <= num_q - dsh_q;
          q_q[cnt_q[3:0]] <= 1'b1;
        end
      end
    end
    if (fin) begin
      if (gediv && cnt_q == 6'(QW - 1))
        cos_q <= neg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      else if (gediv) begin
        if (neg_q) cos_q <= QW'(0) - (q_q | QW'(1));
        else       cos_q <= q_q | QW'(1);
      end else begin
        cos_q <= res;
      end
    end
  end

endmodule

[bench/tb_cosine_similarity.sv]
// ----------------------------------------------------------------------------
// tb_cosine_similarity
// Self-checking bench for the streaming cosine similarity block.
// ----------------------------------------------------------------------------
// A directed table covers single-pair vectors, full-scale and opposite-sign
// pairs, and zero norms. Random vectors of mixed length follow, along with
// one long full-scale vector. A bit-exact predictor models the sums, the
// scaled roots and the divide. Both handshakes idle at random, and the
// receiver holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
module tb_cosine_similarity;
  timeunit 1ns;
  timeprecision 1ps;
  import cosim_pkg::*;

  localparam longint AbMax = 64'h1FFFFFFFFFF;
  localparam longint AbMin = -AbMax - 1;
  localparam longint SqMax = 64'h1FFFFFFFFFF;
  localparam int     StallLimit = 3000;

  typedef struct packed {
    logic signed [ElemW-1:0] cos;
    logic                    zn;
  } cos_res_t;

  typedef struct {
    int       a;
    int       b;
    bit       last;
    bit       typed;
    cos_res_t res;
  } vec_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [ElemW-1:0] a_elem_i = '0;
  logic signed [ElemW-1:0] b_elem_i = '0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [QW-1:0]    cosine_o;
  logic                    zero_norm_o;

  cos_res_t cos_q[$];
  longint   acc_ab, acc_aa, acc_bb;
  int       errors, n_items, n_results, n_zero, n_sat, idle_cnt, hold_cycles;
  bit       quiet;

  cosine_similarity uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [RootW-1:0] scaled_root(logic [RadW-1:0] x);
    logic [RadW+1:0] rem, trial;
    logic [RadW+1:0] r;
    rem = '0;
    r = '0;
    for (int i = RootW - 1; i >= 0; i--) begin
      rem = (rem << 2) | ((x >> (2 * i)) & 2'b11);
      trial = (r << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r[RootW-1:0];
  endfunction

  function automatic logic [QW-1:0] cos_of_sums(longint ab, longint aa, longint bb);
    logic [127:0] num, den, q;
    logic [RadW-1:0] ra, rb;
    longint mag;
    ra = {aa[SqW-1:0], 28'b0};
    rb = {bb[SqW-1:0], 28'b0};
    mag = ab < 0 ? -ab : ab;
    num = 128'(mag) << 43;
    den = 128'(scaled_root(ra)) * 128'(scaled_root(rb));
    q = num / den;
    if (ab < 0) begin
      if (q > 32768) q = 32768;
      return QW'(-q);
    end
    return q > 32767 ? 16'sd32767 : QW'(q);
  endfunction

  // Accumulate one pair; returns 1 with the result when the vector closes.
  function automatic bit accumulate_pair(int a, int b, bit last, output cos_res_t res);
    longint ab;
    ab = acc_ab + longint'(a) * longint'(b);
    acc_ab = ab > AbMax ? AbMax : (ab < AbMin ? AbMin : ab);
    acc_aa = acc_aa + longint'(a) * longint'(a);
    acc_bb = acc_bb + longint'(b) * longint'(b);
    if (acc_aa > SqMax) acc_aa = SqMax;
    if (acc_bb > SqMax) acc_bb = SqMax;
    res = '0;
    if (!last) return 0;
    if (acc_aa == 0 || acc_bb == 0) begin
      res.zn = 1'b1;
    end else begin
      res.cos = cos_of_sums(acc_ab, acc_aa, acc_bb);
    end
    acc_ab = 0;
    acc_aa = 0;
    acc_bb = 0;
    return 1;
  endfunction

  task automatic send_pair(int a, int b, bit last, bit typed = 0, cos_res_t typed_res = '0);
    cos_res_t res;
    logic signed [ElemW-1:0] sa, sb;
    sa = a[ElemW-1:0];
    sb = b[ElemW-1:0];
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    a_elem_i   <= sa;
    b_elem_i   <= sb;
    last_i     <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (accumulate_pair(int'(sa), int'(sb), last, res)) begin
      cos_q.push_back(typed ? typed_res : res);
      if (res.zn) n_zero++;
      if (!res.zn && (res.cos == 16'sh7FFF || res.cos == 16'sh8000)) n_sat++;
    end
    n_items++;
    idle_cnt = 0;
  endtask

  task automatic send_vector(int len, int mode);
    int a, b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin a = $urandom_range(65535) - 32768; b = $urandom_range(65535) - 32768; end
        1: begin a = $urandom_range(65535) - 32768; b = a; end
        2: begin a = $urandom_range(65535) - 32768; b = -a; end
        3: begin a = 0; b = $urandom_range(65535) - 32768; end
        4: begin a = $urandom_range(1) ? 32767 : -32768; b = $urandom_range(1) ? 32767 : -32768; end
        default: begin a = $urandom_range(40) - 20; b = $urandom_range(40) - 20; end
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= !quiet && $urandom_range(99) < 10;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      idle_cnt = 0;
      n_results++;
      if (cos_q.size() == 0) begin
        $display("%0t: unexpected item cosine=%0d zero_norm=%0d", $time, cosine_o, zero_norm_o);
        errors++;
      end else begin
        cos_res_t exp_r;
        exp_r = cos_q.pop_front();
        if (cosine_o !== exp_r.cos) begin
          $display("%0t: cosine expected %0d actual %0d", $time, exp_r.cos, cosine_o);
          errors++;
        end
        if (zero_norm_o !== exp_r.zn) begin
          $display("%0t: zero_norm expected %0d actual %0d", $time, exp_r.zn, zero_norm_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    idle_cnt++;
    if (idle_cnt > StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  vec_row_t dir_rows[18] = '{
    '{16384, 16384, 1, 1, '{16'sd32767, 1'b0}},
    '{0, 5, 1, 1, '{16'sd0, 1'b1}},
    '{5, 0, 1, 1, '{16'sd0, 1'b1}},
    '{0, 0, 1, 1, '{16'sd0, 1'b1}},
    '{-32768, 32767, 1, 1, '{-16'sd32768, 1'b0}},
    '{-32768, -32768, 1, 1, '{16'sd32767, 1'b0}},
    '{32767, 32767, 1, 1, '{16'sd32767, 1'b0}},
    '{100, -3, 0, 0, '{16'sd0, 1'b0}},
    '{-7, 250, 0, 0, '{16'sd0, 1'b0}},
    '{1, 1, 1, 0, '{16'sd0, 1'b0}},
    '{3, 4, 0, 0, '{16'sd0, 1'b0}},
    '{4, -3, 1, 0, '{16'sd0, 1'b0}},
    '{1, 0, 0, 0, '{16'sd0, 1'b0}},
    '{0, 1, 1, 0, '{16'sd0, 1'b0}},
    '{21845, -10922, 0, 0, '{16'sd0, 1'b0}},
    '{-1, 32767, 0, 0, '{16'sd0, 1'b0}},
    '{-21846, 10921, 1, 0, '{16'sd0, 1'b0}},
    '{1, 32767, 1, 0, '{16'sd0, 1'b0}}
  };

  initial begin
    int wait_cnt;
    errors = 0; n_items = 0; n_results = 0; n_zero = 0; n_sat = 0;
    idle_cnt = 0; hold_cycles = 0; quiet = 0;
    acc_ab = 0; acc_aa = 0; acc_bb = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].res);

    // receiver holds off while short vectors pile up
    hold_cycles = 600;
    for (int v = 0; v < 40; v++) send_vector($urandom_range(1, 3), $urandom_range(5));

    // long full-scale vector
    for (int i = 0; i < 1100; i++)
      send_pair(-32768, -32768 + int'(i % 3 == 0), i == 1099);

    while (n_items < 1750) begin
      quiet = n_items > 1300 && n_items < 1550;
      if ($urandom_range(19) == 0) send_vector($urandom_range(20, 60), $urandom_range(5));
      else send_vector($urandom_range(1, 8), $urandom_range(5));
    end
    quiet = 0;
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (cos_q.size() > 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items, a 1100-pair full-scale vector among them; %0d results checked,",
             n_items, n_results);
    $display("%0d with zero norm, %0d at the Q1.15 limits.", n_zero, n_sat);
    if (errors == 0 && cos_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[cosine_similarity.f]
rtl/cosim_pkg.sv
rtl/cosim_front.sv
rtl/cosim_fifo.sv
rtl/cosim_back.sv
rtl/cosine_similarity.sv
bench/tb_cosine_similarity.sv
